>>> sv/bbct_pkg.sv
package bbct_pkg;

	localparam int BUFFERS_DEF = 32;
	localparam int BUCKETS_DEF = 13;

	localparam int DEV_W  = 16;
	localparam int BLK_W  = 32;
	localparam int REFS_W = 8;
	localparam int TIME_W = 32;
	localparam int IDX_W  = 5;
	localparam int BKT_W  = 6;

	localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

	typedef enum logic [1:0] {
		ACT_GET     = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_PIN     = 2'd2,
		ACT_UNPIN   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_COUNT  = 2'd2
	} status_t;

	// one stored entry, bucket of the block kept beside the tag
	localparam int ENTRY_W = DEV_W + BLK_W + REFS_W + TIME_W + 1 + BKT_W;

	typedef struct packed {
		logic [DEV_W-1:0]  device;
		logic [BLK_W-1:0]  block;
		logic [REFS_W-1:0] refs;
		logic [TIME_W-1:0] rtime;
		logic              valid;
		logic [BKT_W-1:0]  bkt;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_MATCH,
		S_BKT,
		S_FREE,
		S_WRITE,
		S_OUT
	} state_t;

endpackage

>>> sv/block_buffer_cache_tags.sv
// channel  | signals                                             | direction
// request  | valid ready action device block_number entry_index now_tick | in
// result   | out_valid out_ready result_index hit need_read status ref_count | out
//
// release, pin, unpin: read, modify, write back.
// get: up to three sweeps over the entry memory (match, bucket victim,
// lowest free), one entry per cycle.
// after reset a clearing pass writes every entry to zero, with ready low. a result
// waits in its output register while out_ready is low.
module block_buffer_cache_tags #(
	parameter int BUFFERS = bbct_pkg::BUFFERS_DEF,
	parameter int BUCKETS = bbct_pkg::BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        ready,
	input  logic [1:0]                  action,
	input  logic [bbct_pkg::DEV_W-1:0]  device,
	input  logic [bbct_pkg::BLK_W-1:0]  block_number,
	input  logic [bbct_pkg::IDX_W-1:0]  entry_index,
	input  logic [bbct_pkg::TIME_W-1:0] now_tick,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bbct_pkg::IDX_W-1:0]  result_index,
	output logic                        hit,
	output logic                        need_read,
	output logic [1:0]                  status,
	output logic [bbct_pkg::REFS_W-1:0] ref_count
);
	import bbct_pkg::*;

	localparam int AW = $clog2(BUFFERS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] LAST = CW'(BUFFERS - 1);

	// request bucket arithmetic: fold at 2^16, then reciprocal multiply
	localparam int FOLD_W = 23;
	localparam int PROD_W = 53;
	localparam int RSH    = 29;
	localparam logic [FOLD_W-1:0] C16   = FOLD_W'(65536 % BUCKETS);
	localparam logic [FOLD_W-1:0] NBKT  = FOLD_W'(BUCKETS);
	localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** RSH + BUCKETS - 1) / BUCKETS);

	// entry number of an index, wrapped at the buffer count
	function automatic logic [AW-1:0] entry_of(logic [IDX_W-1:0] e);
		logic [AW-1:0] r;
		r = '0;
		for (int i = 0; i < 2 ** IDX_W; i++) begin
			if (e == IDX_W'(i)) r = AW'(i % BUFFERS);
		end
		return r;
	endfunction

	state_t state_q, state_d;

	// latched request
	logic [1:0]        act_q;
	logic [DEV_W-1:0]  dev_q;
	logic [BLK_W-1:0]  blk_q;
	logic [AW-1:0]     idx_q;
	logic [TIME_W-1:0] now_q;
	logic [BKT_W-1:0]  bkt_q;

	// scan state
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     pick_q;
	logic              have_q;
	logic [TIME_W-1:0] best_q;

	// memory port
	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic [ENTRY_W-1:0] rraw;

	bbct_ram #(.WIDTH(ENTRY_W), .DEPTH(BUFFERS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rraw)
	);
	assign rdata = entry_t'(rraw);

	// request bucket pipeline (fold_s1, then fold_s2 and quot_s2, then bkt_q),
	// settles before the bucket sweep starts
	logic [FOLD_W-1:0] fold_s1, fold_s2, quot_s2;
	logic [PROD_W-1:0] prod;
	assign prod = PROD_W'(fold_s1) * RECIP;

	always_ff @(posedge clk) begin
		fold_s1 <= FOLD_W'(blk_q[31:16]) * C16 + FOLD_W'(blk_q[15:0]);
		fold_s2 <= fold_s1;
		quot_s2 <= prod[RSH +: FOLD_W];
		bkt_q   <= BKT_W'(fold_s2 - quot_s2 * NBKT);
	end

	// bucket of the stored entry comes from the memory
	logic [BKT_W-1:0] ebkt;
	assign ebkt = rdata.bkt;

	// address of the entry read last cycle
	logic [AW-1:0] cur;
	assign cur = cnt_q[AW-1:0];

	logic          tag_eq, free, bkt_take;
	assign tag_eq   = (rdata.device == dev_q) && (rdata.block == blk_q);
	assign free     = (rdata.refs == '0);
	assign bkt_take = free && (ebkt == bkt_q) && (!have_q || rdata.rtime < best_q);

	// output register
	logic [IDX_W-1:0]  r_idx_q;
	logic              r_hit_q, r_rd_q;
	logic [1:0]        r_st_q;
	logic [REFS_W-1:0] r_refs_q;

	// combinational next-state and memory control
	entry_t        wd;
	logic          load_out;
	logic [IDX_W-1:0]  o_idx;
	logic              o_hit, o_rd;
	logic [1:0]        o_st;
	logic [REFS_W-1:0] o_refs;

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		waddr    = cur;
		raddr    = '0;
		wd       = rdata;
		load_out = 1'b0;
		o_idx    = IDX_W'(idx_q);
		o_hit    = 1'b0;
		o_rd     = 1'b0;
		o_st     = ST_OK;
		o_refs   = rdata.refs;
		ready    = (state_q == S_IDLE) && !out_valid;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				wd    = '0;
				if (cnt_q == LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				raddr = (action == ACT_GET) ? '0 : entry_of(entry_index);
				if (valid && ready) state_d = S_READ;
			end
			S_READ: begin
				raddr   = (act_q == ACT_GET) ? AW'(cnt_q) : idx_q;
				state_d = (act_q == ACT_GET) ? S_MATCH : S_WRITE;
			end
			S_MATCH: begin
				raddr = AW'(cnt_q + 1'b1);
				if (tag_eq) begin
					state_d  = S_OUT;
					load_out = 1'b1;
					o_idx    = IDX_W'(cur);
					o_hit    = 1'b1;
					if (rdata.refs == REFS_MAX) begin
						o_st = ST_COUNT;
					end else begin
						we       = 1'b1;
						wd.refs  = rdata.refs + 1'b1;
						wd.valid = 1'b1;
						o_refs   = wd.refs;
						o_rd     = !rdata.valid;
					end
				end else if (cnt_q == LAST) begin
					state_d = S_BKT;
					raddr   = '0;
				end
			end
			S_BKT: begin
				raddr = AW'(cnt_q + 1'b1);
				if (cnt_q == LAST) begin
					// nothing free in the bucket falls through to the lowest-free sweep
					if (have_q || bkt_take) begin
						raddr   = bkt_take ? cur : pick_q;
						state_d = S_WRITE;
					end else begin
						raddr   = '0;
						state_d = S_FREE;
					end
				end
			end
			S_FREE: begin
				raddr = AW'(cnt_q + 1'b1);
				if (free) begin
					raddr   = cur;
					state_d = S_WRITE;
				end else if (cnt_q == LAST) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				waddr = idx_q;
				if (act_q == ACT_GET) begin
					// victim entry is in rdata, its release time is kept
					load_out = 1'b1;
					state_d  = S_OUT;
					waddr    = pick_q;
					if (!have_q) begin
						o_idx  = '0;
						o_st   = ST_NOFREE;
						o_refs = '0;
					end else begin
						we       = 1'b1;
						wd.device = dev_q;
						wd.block  = blk_q;
						wd.refs   = REFS_W'(1);
						wd.valid  = 1'b1;
						wd.bkt    = bkt_q;
						o_idx    = IDX_W'(pick_q);
						o_rd     = 1'b1;
						o_refs   = REFS_W'(1);
					end
				end else begin
					load_out = 1'b1;
					state_d  = S_OUT;
					if (act_q == ACT_PIN) begin
						if (rdata.refs == REFS_MAX) begin
							o_st = ST_COUNT;
						end else begin
							we      = 1'b1;
							wd.refs = rdata.refs + 1'b1;
						end
					end else begin
						if (rdata.refs == '0) begin
							o_st = ST_COUNT;
						end else begin
							we      = 1'b1;
							wd.refs = rdata.refs - 1'b1;
							if (act_q == ACT_RELEASE && wd.refs == '0) wd.rtime = now_q;
						end
					end
					if (we) o_refs = wd.refs;
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
	assign wdata = wd;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counter, victim tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			have_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
				S_IDLE: begin
					cnt_q  <= '0;
					have_q <= 1'b0;
				end
				S_MATCH: cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
				S_BKT: begin
					if (bkt_take) begin
						have_q <= 1'b1;
						pick_q <= cur;
						best_q <= rdata.rtime;
					end
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
				end
				S_FREE: cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
				default: ;
			endcase
			if (state_q == S_FREE && free && !have_q) begin
				have_q <= 1'b1;
				pick_q <= cur;
			end
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && valid && ready) begin
			act_q <= action;
			dev_q <= device;
			blk_q <= block_number;
			idx_q <= entry_of(entry_index);
			now_q <= now_tick;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			r_idx_q  <= o_idx;
			r_hit_q  <= o_hit;
			r_rd_q   <= o_rd;
			r_st_q   <= o_st;
			r_refs_q <= o_refs;
		end
	end

	assign result_index = r_idx_q;
	assign hit          = r_hit_q;
	assign need_read    = r_rd_q;
	assign status       = r_st_q;
	assign ref_count    = r_refs_q;

endmodule

>>> sv/bbct_ram.sv
module bbct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
